>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL; each reports through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/umlt_pkg.sv
// ----------------------------------------------------------------------------
// umlt_pkg
// Types and fixed-point constants of the Unix-to-Mars local time converter.
// ----------------------------------------------------------------------------
package umlt_pkg;

    // Number of sites with a table entry by default.
    localparam int SITE_COUNT_DEF = 3;
    localparam int SITE_TABLE     = 4;

    // Earth seconds per sol, scaled by 1e10.
    localparam logic [127:0] SOL_SCALED = 128'd887752441468800;

    // Sols per second, Q0.64, rounded to nearest.
    localparam logic [127:0] RATE_W =
        ((128'd10000000000 << 65) + SOL_SCALED) / (SOL_SCALED << 1);
    localparam logic [31:0] RATE_LO = RATE_W[31:0];
    // The rate is below 2^-16 sols per second, so the integer-scaled high
    // half fits in sixteen bits.
    localparam logic [15:0] RATE_HI = RATE_W[47:32];

    // Sol date at the epoch, Q32.32.
    localparam logic [127:0] A_W =
        ((128'd447959990374 << 33) + 128'd10000000) / 128'd20000000;
    localparam logic [127:0] B_W =
        ((128'd9471167308160000000 << 33) + SOL_SCALED) / (SOL_SCALED << 1);
    localparam logic [63:0] MSD_OFF = A_W[63:0] - B_W[63:0];

    // Offset added to Coordinated Mars Time at each site, in hours, Q5.32 in SITE_SHIFT.
    localparam logic [127:0] SHIFT1_W =
        ((128'd7745088572 << 33) + 128'd1500000000) / 128'd3000000000;
    localparam logic [127:0] SHIFT2_W =
        ((128'd137441635 << 33) + 128'd15000000) / 128'd30000000;

    typedef logic [36:0] t_hours;   // hours in Q5.32, below 24 h
    typedef logic [37:0] t_hours_w; // sum of two such values

    localparam t_hours_w DAY_Q = 38'd24 << 32;

    localparam t_hours SITE_SHIFT [SITE_TABLE] = '{
        37'd0, SHIFT1_W[36:0], SHIFT2_W[36:0], 37'd0
    };
    localparam logic [15:0] LANDING_SOL [SITE_TABLE] = '{
        16'd0, 16'd52304, 16'd49269, 16'd0
    };

    typedef struct packed {
        logic [31:0] unix_seconds;
        logic [1:0]  site;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  mars_hour;
        logic [5:0]  mars_minute;
        logic [5:0]  mars_second;
        logic [15:0] mission_sol;
    } t_out_word;

endpackage

>>> hw/rtl/umlt_if.sv
// ----------------------------------------------------------------------------
// umlt_if
// Valid/ready stream interfaces for the input and result words.
// ----------------------------------------------------------------------------
interface umlt_in_if;
    import umlt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface umlt_out_if;
    import umlt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/unix_time_to_mars_local_time.sv
// ----------------------------------------------------------------------------
// unix_time_to_mars_local_time
// Converts UTC Unix seconds into local mean solar time and mission sol on Mars.
// ----------------------------------------------------------------------------
// Usage
// A word on i_in carries a 32-bit Unix time and a site code; each accepted
// word yields exactly one word on o_out with the hour, minute and second of
// local mean solar time at that site and the mission sol number.
// Both channels use valid/ready; a word moves when valid and ready are high
// at the same rising edge of i_clk.
// Throughput is one word per cycle while the receiver is ready: six register
// stages, each holding one word, with the 32-by-32 and 32-by-16
// multiplications of the sol date ahead of the first stage's registers.
// When the receiver stalls, each stage holds only while the one after it is
// full, so empty stages still take words and i_in.ready falls only when all
// six stages are full. Nothing is lost or repeated across a stall.
// A synchronous low i_rst_n empties the pipeline; the data registers are not reset.
// Site codes at or above SITE_COUNT behave as the prime meridian.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unix_time_to_mars_local_time #(
    parameter int SITE_COUNT = umlt_pkg::SITE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    umlt_in_if.sink           i_in,
    umlt_out_if.source        o_out
);
    import umlt_pkg::*;

    localparam int NS = 6;

    // Valid bit of each stage and its enable. A stage loads when it is empty
    // or when the stage after it is loading as well.
    logic [NS-1:0] r_valid;
    logic [NS-1:0] n_valid;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = o_out.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                n_valid[k] = (k == 0) ? i_in.valid : r_valid[(k == 0) ? 0 : k - 1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign i_in.ready = en[0];

    // Stage 1: site lookup and the two partial products of time times rate.
    // The sol date needs only 48 bits: 32 of fraction and 16 of sol number.
    logic [1:0]  site_sel;
    logic [63:0] prod_lo;
    logic [47:0] prod_hi;

    assign site_sel = (int'(i_in.data.site) < SITE_COUNT) ? i_in.data.site : 2'd0;
    assign prod_lo  = 64'(i_in.data.unix_seconds) * 64'(RATE_LO);
    assign prod_hi  = 48'(i_in.data.unix_seconds) * 48'(RATE_HI);

    logic [31:0] r_s1_plo;
    logic [47:0] r_s1_phi;
    t_hours      r_s1_shift;
    logic [15:0] r_s1_land;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_plo   <= prod_lo[63:32];
            r_s1_phi   <= prod_hi;
            r_s1_shift <= SITE_SHIFT[site_sel];
            r_s1_land  <= LANDING_SOL[site_sel];
        end
    end

    // Stage 2: Mars sol date, Q16.32 (the sol number wraps at 16 bits).
    logic [47:0] r_s2_msd;
    t_hours      r_s2_shift;
    logic [15:0] r_s2_land;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s2_msd   <= MSD_OFF[47:0] + r_s1_phi + {16'd0, r_s1_plo};
            r_s2_shift <= r_s1_shift;
            r_s2_land  <= r_s1_land;
        end
    end

    // Stage 3: Coordinated Mars Time (24 times the fraction of a sol) plus
    // the site offset, and the mission sol.
    t_hours_w    r_s3_lmt;
    logic [15:0] r_s3_sol;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s3_lmt <= {2'd0, r_s2_msd[31:0], 4'd0} + {3'd0, r_s2_msd[31:0], 3'd0}
                        + {1'b0, r_s2_shift};
            r_s3_sol <= r_s2_msd[47:32] - r_s2_land;
        end
    end

    // Stage 4: wrap the local time into one day.
    t_hours      r_s4_lmt;
    logic [15:0] r_s4_sol;
    t_hours_w    lmt_wrap;

    assign lmt_wrap = (r_s3_lmt >= DAY_Q) ? (r_s3_lmt - DAY_Q) : r_s3_lmt;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s4_lmt <= lmt_wrap[36:0];
            r_s4_sol <= r_s3_sol;
        end
    end

    // Stage 5: the hour is the integer part; sixty times the fraction of an
    // hour gives the minute and the fraction of a minute.
    logic [37:0] min_q;
    logic [4:0]  r_s5_hour;
    logic [5:0]  r_s5_minute;
    logic [31:0] r_s5_frac;
    logic [15:0] r_s5_sol;

    assign min_q = {r_s4_lmt[31:0], 6'd0} - {4'd0, r_s4_lmt[31:0], 2'd0};

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s5_hour   <= r_s4_lmt[36:32];
            r_s5_minute <= min_q[37:32];
            r_s5_frac   <= min_q[31:0];
            r_s5_sol    <= r_s4_sol;
        end
    end

    // Stage 6: sixty times the fraction of a minute gives the second.
    logic [37:0] sec_q;
    t_out_word   r_s6_out;

    assign sec_q = {r_s5_frac, 6'd0} - {4'd0, r_s5_frac, 2'd0};

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s6_out.mars_hour   <= r_s5_hour;
            r_s6_out.mars_minute <= r_s5_minute;
            r_s6_out.mars_second <= sec_q[37:32];
            r_s6_out.mission_sol <= r_s5_sol;
        end
    end

    assign o_out.valid = r_valid[NS-1];
    assign o_out.data  = r_s6_out;

    // A free output stage must never hold back the input.
    `ASSERT_IMPLY(a_bubble_accepts, i_clk, i_rst_n, !r_valid[NS-1], i_in.ready)
    // The day wrap leaves the local time below 24 hours.
    `ASSERT_IMPLY(a_wrap_range, i_clk, i_rst_n, r_valid[3], r_s4_lmt[36:32] < 5'd24)
    `ASSERT_IMPLY(a_hour_range, i_clk, i_rst_n, o_out.valid, o_out.data.mars_hour < 5'd24)
    `ASSERT_IMPLY(a_minute_range, i_clk, i_rst_n, o_out.valid, o_out.data.mars_minute < 6'd60)
    `ASSERT_IMPLY(a_second_range, i_clk, i_rst_n, o_out.valid, o_out.data.mars_second < 6'd60)

endmodule
